// ===== rtl/prl_pkg.sv =====
// ----------------------------------------------------------------------------
// prl_pkg
// shared types, codes and constants of the peer reply rate limiter
// ----------------------------------------------------------------------------
`default_nettype none

package prl_pkg;

  localparam int SLOTS      = 8;
  localparam int TIME_BITS  = 48;
  localparam int ID_W       = 32;
  localparam int BUDGET_W   = 8;
  localparam int VERDICT_W  = 3;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = ((ID_W + 1 + TIME_BITS + 7) / 8) * 8;
  localparam int OUT_FIELDS = 1 + VERDICT_W + 1;
  localparam int OUT_DATA_W = ((OUT_FIELDS + 7) / 8) * 8;

  localparam logic [VERDICT_W-1:0] V_ALLOWED   = 3'd0;
  localparam logic [VERDICT_W-1:0] V_DISABLED  = 3'd1;
  localparam logic [VERDICT_W-1:0] V_AUTOMATED = 3'd2;
  localparam logic [VERDICT_W-1:0] V_OWN       = 3'd3;
  localparam logic [VERDICT_W-1:0] V_BUDGET    = 3'd4;
  localparam logic [VERDICT_W-1:0] V_COOLING   = 3'd5;
  localparam logic [VERDICT_W-1:0] V_CLEARED   = 3'd6;

  localparam logic [CFG_ADDR_W-1:0] REG_BOT_ENABLE = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OWN_ID     = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COOLDOWN   = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BUDGET     = 8'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW     = 8'd4;

  localparam logic [31:0]         COOLDOWN_RESET = 32'd30000000;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET   = 8'd6;
  localparam logic [31:0]         WINDOW_RESET   = 32'd60000000;

  typedef struct packed {
    logic load;
    logic eval;
    logic decide;
    logic emit;
  } prl_cmd_t;

  typedef struct packed {
    logic early_done;
  } prl_stat_t;

endpackage

`default_nettype wire

// ===== rtl/prl_ctrl.sv =====
// ----------------------------------------------------------------------------
// prl_ctrl
// sequencer: accept, evaluate, decide, emit; owns the result valid flag
// ----------------------------------------------------------------------------
`default_nettype none

module prl_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire prl_pkg::prl_stat_t stat,
  output prl_pkg::prl_cmd_t     cmd
);
  import prl_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EVAL   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready   = (state == S_IDLE) && !rst;
  assign cmd.load   = in_valid && in_ready;
  assign cmd.eval   = (state == S_EVAL);
  assign cmd.decide = (state == S_DECIDE);
  assign cmd.emit   = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = stat.early_done ? S_EMIT : S_DECIDE;
      end
      S_DECIDE: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (cmd.emit) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_load_to_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_EVAL))
    else $error("accepted beat did not enter evaluation");

  a_hold_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_valid && !out_ready) |=> (state == S_EMIT && out_valid))
    else $error("pending result overwritten or dropped");

  a_rise_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EMIT))
    else $error("result valid raised outside emit");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |=> !in_ready)
    else $error("input accepted before result emitted");

endmodule

`default_nettype wire

// ===== rtl/prl_dp.sv =====
// ----------------------------------------------------------------------------
// prl_dp
// datapath: config registers, cooldown table, window budget and verdict logic
// ----------------------------------------------------------------------------
`default_nettype none

module prl_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire prl_pkg::prl_cmd_t                   cmd,
  output prl_pkg::prl_stat_t                       stat,
  input  wire logic [prl_pkg::IN_DATA_W-1:0]       in_data,
  input  wire logic                                in_user,
  input  wire logic                                cfg_we,
  input  wire logic [prl_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [prl_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [prl_pkg::OUT_DATA_W-1:0]           out_data
);
  import prl_pkg::*;

  function automatic logic [SLOTS-1:0] first_one(input logic [SLOTS-1:0] v);
    return v & (~v + SLOTS'(1));
  endfunction

  // config
  logic                bot_enable;
  logic [ID_W-1:0]     own_id;
  logic [31:0]         peer_cooldown_us;
  logic [BUDGET_W-1:0] budget_per_window;
  logic [31:0]         window_us;

  // latched beat
  logic                 in_command;
  logic [ID_W-1:0]      in_sender;
  logic                 in_auto;
  logic [TIME_BITS-1:0] in_now;

  // table and window state
  logic [ID_W-1:0]      slot_id    [SLOTS];
  logic [TIME_BITS-1:0] slot_stamp [SLOTS];
  logic [SLOTS-1:0]     slot_used;
  logic [TIME_BITS-1:0] window_start;
  logic [BUDGET_W-1:0]  budget_left;
  logic                 warned;

  // evaluation results
  logic [SLOTS-1:0] match_q;
  logic [SLOTS-1:0] free_q;
  logic [SLOTS-1:0] oldest_q;

  logic                 res_allowed;
  logic [VERDICT_W-1:0] res_verdict;
  logic                 res_warn;

  logic                 early_done;
  logic [VERDICT_W-1:0] early_verdict;
  logic                 roll;
  logic [SLOTS-1:0]     match_vec;
  logic [SLOTS-1:0]     oldest_vec;
  logic [SLOTS-1:0]     match_first;
  logic [SLOTS-1:0]     target;
  logic [TIME_BITS-1:0] match_stamp;
  logic                 cooling;

  always_ff @(posedge clk) begin
    if (rst) begin
      bot_enable        <= 1'b0;
      own_id            <= '0;
      peer_cooldown_us  <= COOLDOWN_RESET;
      budget_per_window <= BUDGET_RESET;
      window_us         <= WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BOT_ENABLE: bot_enable        <= cfg_data[0];
        REG_OWN_ID:     own_id            <= cfg_data[ID_W-1:0];
        REG_COOLDOWN:   peer_cooldown_us  <= cfg_data;
        REG_BUDGET:     budget_per_window <= cfg_data[BUDGET_W-1:0];
        REG_WINDOW:     window_us         <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_command <= in_user;
      in_sender  <= in_data[ID_W-1:0];
      in_auto    <= in_data[ID_W];
      in_now     <= in_data[ID_W+1+:TIME_BITS];
    end
  end

  always_comb begin
    early_done    = 1'b1;
    early_verdict = V_CLEARED;
    if (in_command)              early_verdict = V_CLEARED;
    else if (!bot_enable)        early_verdict = V_DISABLED;
    else if (in_auto)            early_verdict = V_AUTOMATED;
    else if (in_sender == own_id) early_verdict = V_OWN;
    else                         early_done = 1'b0;
  end

  assign stat.early_done = early_done;
  assign roll = ((in_now - window_start) >= TIME_BITS'(window_us));

  // first minimum stamp: strictly below every earlier slot, not above any later one
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_vec[i]  = slot_used[i] && (slot_id[i] == in_sender);
      oldest_vec[i] = 1'b1;
      for (int j = 0; j < SLOTS; j++) begin
        if (j < i && !(slot_stamp[i] < slot_stamp[j])) oldest_vec[i] = 1'b0;
        if (j > i && (slot_stamp[i] > slot_stamp[j]))  oldest_vec[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      match_q  <= match_vec;
      free_q   <= ~slot_used;
      oldest_q <= oldest_vec;
    end
  end

  always_comb begin
    match_first = first_one(match_q);
    match_stamp = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match_first[i]) match_stamp = match_stamp | slot_stamp[i];
    end
    cooling = (|match_q) && ((in_now - match_stamp) < TIME_BITS'(peer_cooldown_us));
    if (|match_q)     target = match_first;
    else if (|free_q) target = first_one(free_q);
    else              target = oldest_q;
  end

  wire allow_now = cmd.decide && (budget_left != '0) && !cooling;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      budget_left  <= BUDGET_RESET;
      warned       <= 1'b0;
    end else if (cmd.eval) begin
      if (in_command) begin
        window_start <= '0;
      end else if (!early_done && roll) begin
        window_start <= in_now;
        budget_left  <= budget_per_window;
        warned       <= 1'b0;
      end
    end else if (cmd.decide) begin
      if (budget_left == '0) warned <= 1'b1;
      else if (!cooling)     budget_left <= budget_left - BUDGET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_id[i]    <= '0;
        slot_stamp[i] <= '0;
      end
    end else if (cmd.eval && in_command) begin
      slot_used <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_id[i]    <= '0;
        slot_stamp[i] <= '0;
      end
    end else if (allow_now) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (target[i]) begin
          slot_used[i]  <= 1'b1;
          slot_id[i]    <= in_sender;
          slot_stamp[i] <= in_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_allowed <= 1'b0;
      res_verdict <= early_verdict;
      res_warn    <= 1'b0;
    end else if (cmd.decide) begin
      if (budget_left == '0) begin
        res_allowed <= 1'b0;
        res_verdict <= V_BUDGET;
        res_warn    <= !warned;
      end else if (cooling) begin
        res_allowed <= 1'b0;
        res_verdict <= V_COOLING;
        res_warn    <= 1'b0;
      end else begin
        res_allowed <= 1'b1;
        res_verdict <= V_ALLOWED;
        res_warn    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {(OUT_DATA_W - OUT_FIELDS)'(0), res_warn, res_verdict, res_allowed};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/peer_reply_rate_limiter_top.sv =====
// ----------------------------------------------------------------------------
// peer_reply_rate_limiter_top
// per-sender cooldown with a fixed-window global reply budget
// ----------------------------------------------------------------------------
// flow: an accepted beat is latched and evaluated; events reaching the budget and
//   cooldown checks then pass decide, clears and early refusals go straight to emit
// one beat at a time: a new beat is accepted only after emit, the sequencer stepping
//   accept, evaluate, decide and emit over the single cooldown table
// reset: synchronous, clears table, window start and warning, loads register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module peer_reply_rate_limiter_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // src_id[31:0], automated[32], now_us[80:33], zero pad
  input  wire logic [prl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // command[0]
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // allowed[0], verdict[3:1], budget_warning[4], zero pad
  output logic [prl_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [prl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [prl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import prl_pkg::*;

  prl_cmd_t  cmd;
  prl_stat_t stat;

  assign cfg_ready = !rst;

  prl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  prl_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (s_axis_tdata),
    .in_user  (s_axis_tuser),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .out_data (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== dv/reply_limit_checker.sv =====
// ----------------------------------------------------------------------------
// reply_limit_checker
// watches the event, reply and register channels of the peer reply rate
// limiter, keeps its own copy of the cooldown table, window and budget,
// predicts the reply for every accepted event beat and compares each reply
// beat field by field against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reply_limit_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  input  wire logic                             s_axis_tready,
  input  wire logic [prl_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  wire logic                             s_axis_tuser,
  input  wire logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  input  wire logic [prl_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [prl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [prl_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                    fail_count,
  output int                                    results_seen
);
  import prl_pkg::*;

  typedef struct packed {
    logic                 warning;
    logic [VERDICT_W-1:0] verdict;
    logic                 allowed;
  } reply_t;

  logic                 bot_on;
  logic [ID_W-1:0]      own_id_r;
  logic [31:0]          cooldown_us;
  logic [BUDGET_W-1:0]  budget_cap;
  logic [31:0]          window_len;

  logic [ID_W-1:0]      slot_id    [SLOTS];
  logic [TIME_BITS-1:0] slot_stamp [SLOTS];
  logic                 slot_used  [SLOTS];
  logic [TIME_BITS-1:0] window_start;
  logic [BUDGET_W-1:0]  budget_left;
  logic                 warned;

  reply_t replies_due[$];
  int     fails;
  int     seen;

  function automatic void wipe_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_id[i]    = '0;
      slot_stamp[i] = '0;
      slot_used[i]  = 1'b0;
    end
    window_start = '0;
  endfunction

  function automatic reply_t predict_reply(input logic is_clear, input logic [ID_W-1:0] sid,
                                           input logic auto_f, input logic [TIME_BITS-1:0] now);
    reply_t               r;
    logic [TIME_BITS-1:0] age;
    int                   pick;
    int                   oldest;
    r.allowed = 1'b0;
    r.warning = 1'b0;
    r.verdict = V_ALLOWED;
    if (is_clear) begin
      wipe_table();
      r.verdict = V_CLEARED;
      return r;
    end
    if (!bot_on) begin
      r.verdict = V_DISABLED;
      return r;
    end
    if (auto_f) begin
      r.verdict = V_AUTOMATED;
      return r;
    end
    if (sid == own_id_r) begin
      r.verdict = V_OWN;
      return r;
    end
    age = now - window_start;
    if (age >= TIME_BITS'(window_len)) begin
      window_start = now;
      budget_left  = budget_cap;
      warned       = 1'b0;
    end
    if (budget_left == '0) begin
      r.verdict = V_BUDGET;
      r.warning = !warned;
      warned    = 1'b1;
      return r;
    end
    pick   = -1;
    oldest = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_id[i] == sid) begin
        age = now - slot_stamp[i];
        if (age < TIME_BITS'(cooldown_us)) begin
          r.verdict = V_COOLING;
          return r;
        end
        pick = i;
        break;
      end
      if (!slot_used[i] && pick < 0) pick = i;
      if (slot_stamp[i] < slot_stamp[oldest]) oldest = i;
    end
    if (pick < 0) pick = oldest;
    slot_used[pick]  = 1'b1;
    slot_id[pick]    = sid;
    slot_stamp[pick] = now;
    budget_left      = budget_left - BUDGET_W'(1);
    r.allowed        = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    fails++;
    if (fails <= 10)
      $display("%0t: reply mismatch on %s, expected %0d, got %0d", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst) begin
      bot_on      = 1'b0;
      own_id_r    = '0;
      cooldown_us = COOLDOWN_RESET;
      budget_cap  = BUDGET_RESET;
      window_len  = WINDOW_RESET;
      budget_left = BUDGET_RESET;
      warned      = 1'b0;
      wipe_table();
      replies_due.delete();
      fails = 0;
      seen  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_BOT_ENABLE: bot_on = cfg_data[0];
          REG_OWN_ID:     own_id_r = cfg_data[ID_W-1:0];
          REG_COOLDOWN:   cooldown_us = cfg_data[31:0];
          REG_BUDGET:     budget_cap = cfg_data[BUDGET_W-1:0];
          REG_WINDOW:     window_len = cfg_data[31:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        replies_due.push_back(predict_reply(s_axis_tuser, s_axis_tdata[ID_W-1:0],
                                            s_axis_tdata[ID_W],
                                            s_axis_tdata[ID_W+TIME_BITS:ID_W+1]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[OUT_FIELDS-1:0];
        seen++;
        if (replies_due.size() == 0) begin
          report_mismatch("unrequested reply verdict", -1, int'(got.verdict));
        end else begin
          want = replies_due.pop_front();
          if (got.allowed !== want.allowed)
            report_mismatch("allowed", int'(want.allowed), int'(got.allowed));
          if (got.verdict !== want.verdict)
            report_mismatch("verdict", int'(want.verdict), int'(got.verdict));
          if (got.warning !== want.warning)
            report_mismatch("budget_warning", int'(want.warning), int'(got.warning));
        end
      end
    end
    fail_count   <= fails;
    results_seen <= seen;
  end

endmodule

// ===== dv/peer_reply_rate_limiter_top_test.sv =====
// ----------------------------------------------------------------------------
// peer_reply_rate_limiter_top_test
// drives chat events and register writes into the rate limiter: a directed
// pass over every refusal reason, eviction, window roll, time wrap and clear,
// then random traffic under several register settings with bursty input,
// a stalling reply side and one long reply hold-off; the checker judges
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peer_reply_rate_limiter_top_test;
  import prl_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 8'd7;
  localparam logic CMD_JUDGE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;
  localparam int PEER_POOL       = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 12;
  localparam logic [TIME_BITS-1:0] T_MAX = '1;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  hold_off_go = 1'b0;

  int fail_count;
  int results_seen;
  int sent_n;
  int burst_left;
  logic [ID_W-1:0] peer_pool [PEER_POOL];

  always #10 clk = ~clk;

  peer_reply_rate_limiter_top dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data)
  );

  reply_limit_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_seen (results_seen)
  );

  task automatic offer_event(input logic cmd, input logic [ID_W-1:0] sid, input logic auto_f,
                             input logic [TIME_BITS-1:0] now);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    burst_left--;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_DATA_W-ID_W-1-TIME_BITS){1'b0}}, now, auto_f, sid};
    do @(posedge clk); while (!s_axis_tready);
    sent_n++;
  endtask

  // stop offering and wait for every reply owed so far
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (results_seen < sent_n) @(posedge clk);
  endtask

  task automatic program_regs(input logic en, input logic [31:0] own, input logic [31:0] cool,
                              input logic [7:0] bud, input logic [31:0] win,
                              input bit poke_unused);
    logic [CFG_ADDR_W-1:0] addr_list [6];
    logic [CFG_DATA_W-1:0] data_list [6];
    int n;
    settle();
    addr_list = '{REG_BOT_ENABLE, REG_OWN_ID, REG_COOLDOWN, REG_BUDGET, REG_WINDOW, REG_UNUSED};
    data_list = '{{31'd0, en}, own, cool, {24'd0, bud}, win, $urandom};
    n = poke_unused ? 6 : 5;
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_addr  <= addr_list[k];
      cfg_data  <= data_list[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic en, input logic [31:0] cool, input logic [7:0] bud,
                           input logic [31:0] win, input int unsigned tick, input int count,
                           input bit with_hold);
    logic [ID_W-1:0]      own;
    logic [ID_W-1:0]      sid;
    logic [TIME_BITS-1:0] now;
    logic                 cmd;
    int                   pick;
    own = $urandom;
    program_regs(en, own, cool, bud, win, 1'b0);
    now = TIME_BITS'($urandom_range(0, 100000));
    for (int k = 0; k < count; k++) begin
      if (with_hold && k == 5) hold_off_go <= 1'b1;
      cmd  = ($urandom_range(0, 99) < 3) ? CMD_CLEAR : CMD_JUDGE;
      pick = $urandom_range(0, 99);
      if (pick < 5)       sid = own;
      else if (pick < 10) sid = $urandom;
      else                sid = peer_pool[$urandom_range(0, PEER_POOL-1)];
      pick = $urandom_range(0, 99);
      if (pick < 4)       now = TIME_BITS'({$urandom, $urandom});
      else if (pick < 8)  now = now - TIME_BITS'($urandom_range(0, tick));
      else if (pick < 11) now = T_MAX - TIME_BITS'($urandom_range(0, tick));
      else                now = now + TIME_BITS'($urandom_range(0, tick));
      offer_event(cmd, sid, ($urandom_range(0, 19) == 0), now);
    end
  endtask

  initial begin : reply_side
    rx_mode_t mode;
    int       span;
    bit       held;
    held = 1'b0;
    forever begin
      if (hold_off_go && !held) begin
        held = 1'b1;
        repeat (HOLD_OFF_CYCLES) begin
          @(posedge clk);
          m_axis_tready <= 1'b0;
        end
      end
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(4, 64);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready <= ~m_axis_tready;
        endcase
      end
    end
  end

  initial begin : watchdog
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    sent_n     = 0;
    burst_left = 0;
    for (int i = 0; i < PEER_POOL; i++) peer_pool[i] = $urandom;
    peer_pool[0] = '0;
    peer_pool[1] = '1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // register defaults: responder off, clear works anyway
    offer_event(CMD_JUDGE, 32'h0, 1'b0, 48'd0);
    offer_event(CMD_CLEAR, 32'h1234_5678, 1'b0, 48'd10);
    program_regs(1'b1, 32'hA5A5_0001, 32'd100, 8'd3, 32'd1000, 1'b1);
    offer_event(CMD_JUDGE, 32'h0000_0009, 1'b1, 48'd0);
    offer_event(CMD_JUDGE, 32'hA5A5_0001, 1'b0, 48'd0);
    // fill slots until the leftover budget runs out
    offer_event(CMD_JUDGE, 32'h0000_0000, 1'b0, 48'd0);
    offer_event(CMD_JUDGE, 32'h0000_0000, 1'b0, 48'd50);
    offer_event(CMD_JUDGE, 32'hFFFF_FFFF, 1'b0, 48'd60);
    offer_event(CMD_JUDGE, 32'h0000_0001, 1'b0, 48'd70);
    offer_event(CMD_JUDGE, 32'h0000_0002, 1'b0, 48'd80);
    offer_event(CMD_JUDGE, 32'h0000_0003, 1'b0, 48'd90);
    offer_event(CMD_JUDGE, 32'h0000_0004, 1'b0, 48'd95);
    offer_event(CMD_JUDGE, 32'h0000_0005, 1'b0, 48'd100);
    offer_event(CMD_JUDGE, 32'h0000_0006, 1'b0, 48'd110);
    // window roll, then time stepping backwards and across the wrap
    offer_event(CMD_JUDGE, 32'h0000_0000, 1'b0, 48'd1000);
    offer_event(CMD_JUDGE, 32'h0000_0001, 1'b0, 48'd500);
    offer_event(CMD_JUDGE, 32'h0000_0007, 1'b0, T_MAX);
    offer_event(CMD_JUDGE, 32'h0000_0008, 1'b0, 48'd5);
    offer_event(CMD_JUDGE, 32'h0000_0009, 1'b0, 48'd6);
    offer_event(CMD_JUDGE, 32'h0000_000A, 1'b0, 48'd7);
    offer_event(CMD_CLEAR, 32'h0, 1'b1, T_MAX);
    offer_event(CMD_JUDGE, 32'h0000_0007, 1'b0, T_MAX);
    offer_event(CMD_JUDGE, 32'h0000_0007, 1'b0, T_MAX - 48'd10);

    run_phase(1'b1, 32'd100,      8'd3,   32'd1000,     60,       80,  1'b1);
    run_phase(1'b1, 32'd0,        8'd255, 32'd1,        3,        70,  1'b0);
    run_phase(1'b1, 32'hFFFF_FFFF, 8'd0,  32'hFFFF_FFFF, 1000,    50,  1'b0);
    run_phase(1'b1, 32'd50,       8'd8,   32'd0,        40,       70,  1'b0);
    run_phase(1'b0, 32'd100,      8'd3,   32'd1000,     60,       30,  1'b0);
    run_phase(1'b1, 32'd30000000, 8'd6,   32'd60000000, 20000000, 80,  1'b0);
    run_phase(1'b1, 32'd200,      8'd5,   32'd2000,     120,      100, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_seen == sent_n) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/prl_pkg.sv
rtl/prl_ctrl.sv
rtl/prl_dp.sv
rtl/peer_reply_rate_limiter_top.sv
dv/reply_limit_checker.sv
dv/peer_reply_rate_limiter_top_test.sv
